// ===== rtl/core/sbfd_pkg.sv =====
// Package: shared types and constants for the servo bus frame decoder.
`default_nettype none

package sbfd_pkg;

  // Header byte that opens every frame (sent twice)
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Shortest legal length byte (status plus checksum)
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_BAD_SUM   = 2'd2,
    KIND_SHORT_LEN = 2'd3
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame_id;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbfd_if.sv =====
// Interfaces: input byte channel and result channel of the frame decoder.
`default_nettype none

interface sbfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] frame_id;
  logic [7:0] data_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_length;
  logic       last;

  modport source (output valid, output kind, output frame_id, output data_byte,
                  output payload_index, output frame_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input frame_id, input data_byte,
                  input payload_index, input frame_length, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sbfd_fsm.sv =====
// Frame state machine: header hunt, id/length capture, payload and checksum.
`default_nettype none

module sbfd_fsm (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             beat_i,
  input  wire logic [7:0]       rx_byte_i,
  output sbfd_pkg::result_t     res_o,
  output logic                  res_valid_o
);

  sbfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_length_r, held_length_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] count_inc;
  logic [7:0] expect_sum;

  assign count_inc  = byte_count_r + 8'd1;
  assign expect_sum = ~running_sum_r;

  // Next phase and frame context
  always_comb begin
    phase_nxt       = phase_r;
    held_id_nxt     = held_id_r;
    held_length_nxt = held_length_r;
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    if (beat_i) begin
      case (phase_r)
        sbfd_pkg::PH_HUNT2: begin
          phase_nxt = (rx_byte_i == sbfd_pkg::HDR_BYTE) ? sbfd_pkg::PH_ID
                                                        : sbfd_pkg::PH_HUNT1;
        end
        sbfd_pkg::PH_ID: begin
          held_id_nxt = rx_byte_i;
          phase_nxt   = sbfd_pkg::PH_LEN;
        end
        sbfd_pkg::PH_LEN: begin
          held_length_nxt = rx_byte_i;
          if (rx_byte_i < sbfd_pkg::MIN_LENGTH) begin
            phase_nxt = sbfd_pkg::PH_HUNT1;
          end else begin
            running_sum_nxt = held_id_r + rx_byte_i;
            byte_count_nxt  = 8'd0;
            phase_nxt       = sbfd_pkg::PH_PAYLOAD;
          end
        end
        sbfd_pkg::PH_PAYLOAD: begin
          running_sum_nxt = running_sum_r + rx_byte_i;
          byte_count_nxt  = count_inc;
          // Status plus (length - 2) parameters, then the checksum
          if (count_inc >= (held_length_r - 8'd1)) begin
            phase_nxt = sbfd_pkg::PH_CHECK;
          end
        end
        sbfd_pkg::PH_CHECK: begin
          phase_nxt = sbfd_pkg::PH_HUNT1;
        end
        default: begin
          phase_nxt = (rx_byte_i == sbfd_pkg::HDR_BYTE) ? sbfd_pkg::PH_HUNT2
                                                        : sbfd_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // Result for the current beat
  always_comb begin
    res_valid_o         = 1'b0;
    res_o.kind          = sbfd_pkg::KIND_PAYLOAD;
    res_o.frame_id      = held_id_r;
    res_o.data_byte     = 8'd0;
    res_o.payload_index = 8'd0;
    res_o.frame_length  = held_length_r;
    res_o.last          = 1'b0;
    case (phase_r)
      sbfd_pkg::PH_LEN: begin
        res_o.frame_length = rx_byte_i;
        if (rx_byte_i < sbfd_pkg::MIN_LENGTH) begin
          res_valid_o = beat_i;
          res_o.kind  = sbfd_pkg::KIND_SHORT_LEN;
          res_o.last  = 1'b1;
        end
      end
      sbfd_pkg::PH_PAYLOAD: begin
        res_valid_o         = beat_i;
        res_o.data_byte     = rx_byte_i;
        res_o.payload_index = byte_count_r;
      end
      sbfd_pkg::PH_CHECK: begin
        res_valid_o = beat_i;
        res_o.kind  = (rx_byte_i == expect_sum) ? sbfd_pkg::KIND_GOOD
                                                : sbfd_pkg::KIND_BAD_SUM;
        res_o.last  = 1'b1;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  // Hold phase and frame context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sbfd_pkg::PH_HUNT1;
      held_id_r     <= 8'd0;
      held_length_r <= 8'd0;
      byte_count_r  <= 8'd0;
      running_sum_r <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      held_id_r     <= held_id_nxt;
      held_length_r <= held_length_nxt;
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/servo_bus_frame_decoder_top.sv =====
// Servo bus status frame decoder (0xFF 0xFF id length status params checksum).
//
// Channels: in_ch carries one received bus byte per beat; out_ch carries zero or
// one result per input byte. Payload results (status byte first, then the
// parameters) come with an index; the checksum byte or a length below two gives
// a verdict result with last set. Header, id and valid length bytes give none.
// Each result is registered and appears on out_ch in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled in the
// same cycle it is drained, so in_ch.ready stays high while out_ch is taken.
// Stall: while a result waits in the output register and out_ch.ready is low,
// in_ch.ready drops and no byte is taken; nothing is lost or repeated.
// Reset (rst_n low, synchronous): output register empties and the decoder
// returns to hunting for the first header byte with a cleared frame context.
// After every verdict the decoder hunts for a new header.
`default_nettype none

module servo_bus_frame_decoder_top (
  input  wire logic clk,
  input  wire logic rst_n,
  sbfd_in_if.sink   in_ch,
  sbfd_out_if.source out_ch
);

  logic              in_beat;
  logic              res_valid;
  sbfd_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  sbfd_pkg::result_t out_res_r;

  // Take a byte whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  sbfd_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_i      (in_beat),
    .rx_byte_i   (in_ch.rx_byte),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // Advance output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_ch.ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_res_r.kind;
  assign out_ch.frame_id      = out_res_r.frame_id;
  assign out_ch.data_byte     = out_res_r.data_byte;
  assign out_ch.payload_index = out_res_r.payload_index;
  assign out_ch.frame_length  = out_res_r.frame_length;
  assign out_ch.last          = out_res_r.last;

`ifndef SYNTHESIS
  // Empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // A byte that yields a result shows up as a valid beat next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && res_valid) |=> out_valid_r)
    else $error("result lost in output register");

  // Verdicts carry last and no payload; payload beats never carry last
  a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_ch.last == (out_ch.kind != sbfd_pkg::KIND_PAYLOAD)) &&
                     (!out_ch.last ||
                      (out_ch.data_byte == 8'd0 && out_ch.payload_index == 8'd0))))
    else $error("malformed verdict or payload result");
`endif

endmodule

`default_nettype wire

// ===== verif/sbfd_frame_checker.sv =====
// Checker: watches both decoder channels, predicts every result beat and compares it.
`timescale 1ns / 1ps

module sbfd_frame_checker
  import sbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sbfd_in_if          in_mon,
  sbfd_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned results_outstanding
);

  // Predicted decoder context
  phase_t     phase;
  logic [7:0] held_id;
  logic [7:0] held_length;
  logic [7:0] byte_count;
  logic [7:0] running_sum;

  // Results predicted but not yet seen on the output channel, oldest first
  result_t awaited_results[$];

  // Queue one predicted result tagged with the current frame context
  task automatic queue_result(input kind_t k, input logic [7:0] data,
                              input logic [7:0] idx, input logic is_last);
    result_t r;
    r.kind          = k;
    r.frame_id      = held_id;
    r.data_byte     = data;
    r.payload_index = idx;
    r.frame_length  = held_length;
    r.last          = is_last;
    awaited_results = {awaited_results, r};
  endtask

  // Advance the frame decoder by one received byte
  task automatic decode_rx_byte(input logic [7:0] b);
    case (phase)
      PH_HUNT2: phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
      PH_ID: begin
        held_id = b;
        phase   = PH_LEN;
      end
      PH_LEN: begin
        held_length = b;
        if (b < MIN_LENGTH) begin
          queue_result(KIND_SHORT_LEN, 8'd0, 8'd0, 1'b1);
          phase = PH_HUNT1;
        end else begin
          running_sum = held_id + b;
          byte_count  = 8'd0;
          phase       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        queue_result(KIND_PAYLOAD, b, byte_count, 1'b0);
        running_sum = running_sum + b;
        byte_count  = byte_count + 8'd1;
        if (byte_count >= held_length - 8'd1) phase = PH_CHECK;
      end
      PH_CHECK: begin
        queue_result((b == ~running_sum) ? KIND_GOOD : KIND_BAD_SUM, 8'd0, 8'd0, 1'b1);
        phase = PH_HUNT1;
      end
      default: phase = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare output beats first: a byte taken at this edge is answered in the next cycle at the earliest
  always @(posedge clk) begin : watch_beats
    result_t want;
    if (!rst_n) begin
      phase       = PH_HUNT1;
      held_id     = 8'd0;
      held_length = 8'd0;
      byte_count  = 8'd0;
      running_sum = 8'd0;
      awaited_results.delete();
      fail_count  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with none expected: kind %0d, data 0x%02h",
                 out_mon.kind, out_mon.data_byte);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_mon.kind));
          check_field("frame_id", want.frame_id, out_mon.frame_id);
          check_field("data_byte", want.data_byte, out_mon.data_byte);
          check_field("payload_index", want.payload_index, out_mon.payload_index);
          check_field("frame_length", want.frame_length, out_mon.frame_length);
          check_field("last", 8'(want.last), 8'(out_mon.last));
        end
      end
      if (in_mon.valid && in_mon.ready) decode_rx_byte(in_mon.rx_byte);
    end
    results_outstanding = awaited_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top: clock, reset, byte stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module tb;
  import sbfd_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned fail_count;
  int unsigned results_outstanding;

  // Upper bound of the random wait drawn per beat on each side
  int unsigned src_max_gap  = 4;
  int unsigned sink_max_gap = 4;
  int unsigned bytes_sent   = 0;

  sbfd_in_if  in_ch ();
  sbfd_out_if out_ch ();

  servo_bus_frame_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sbfd_frame_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one byte after a random gap; return at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    bytes_sent++;
  endtask

  // Send header, id, length, payload and checksum; fill below zero means random payload
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input bit corrupt, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(id);
    send_byte(len);
    if (len >= MIN_LENGTH) begin
      sum = id + len;
      for (int i = 0; i < int'(len) - 1; i++) begin
        b   = (fill < 0) ? 8'($urandom) : 8'(fill);
        sum = sum + b;
        send_byte(b);
      end
      chk = ~sum;
      if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk);
    end
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
  endtask

  // Result side: random stall before each beat
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, sink_max_gap);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready && rst_n));
      @(negedge clk);
    end
  end

  initial begin : byte_source
    int unsigned pick;
    bit drained_mid;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    drained_mid   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: noise, broken header, shortest frame, third 0xFF as id,
    // short lengths, checksum mismatch
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_byte(8'h12);
    send_frame(8'h00, MIN_LENGTH, 1'b0, 0);
    send_frame(HDR_BYTE, 8'd3, 1'b0, 255);
    send_frame(8'h7E, 8'd0, 1'b0, -1);
    send_frame(8'h81, 8'd1, 1'b0, -1);
    send_frame(8'h20, 8'd3, 1'b1, -1);
    drain_results();

    // Random: mostly well-formed frames, the rest broken frames and noise
    while (bytes_sent < 1600) begin
      if ($urandom_range(0, 7) == 0) begin
        src_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 4;
        sink_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_frame(8'($urandom), ($urandom_range(0, 1) != 0) ? 8'd255 :
                   8'($urandom_range(100, 254)), 1'b0, -1);
      end else if (pick < 70) begin
        send_frame(8'($urandom), 8'($urandom_range(2, 12)), 1'b0, -1);
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'($urandom_range(2, 12)), 1'b1, -1);
      end else if (pick < 86) begin
        send_frame(8'($urandom), 8'($urandom_range(0, 1)), 1'b0, -1);
      end else if (pick < 93) begin
        // Truncated frame: the next header lands inside its payload
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(2, 20)));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
      end
      if (!drained_mid && bytes_sent >= 800) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
